FILE: src/tpt_pkg.sv
// shared constants, codes and control structs for the tlb page table translator
// no dependencies; imported by every module of the block
package tpt_pkg;

  localparam int PAGE_COUNT_DEF  = 256;
  localparam int FRAME_COUNT_DEF = 256;
  localparam int TLB_ENTRIES_DEF = 16;

  localparam int OFFSET_BITS   = 8;
  localparam int VA_W          = 16;
  localparam int PAGE_FIELD_W  = 8;
  localparam int FRAME_FIELD_W = 8;
  localparam int CFG_W         = 9;
  localparam int CNT_W         = 32;
  localparam int TLB_IDX_MAX_W = 6;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 9'd256;

  typedef enum logic [1:0] {
    OC_TLB_HIT = 2'd0,
    OC_PT_HIT  = 2'd1,
    OC_FAULT   = 2'd2
  } outcome_e;

  // tlb update: optional removal, then optional fifo insert
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [TLB_IDX_MAX_W-1:0] rem_idx;
    logic [PAGE_FIELD_W-1:0]  page;
    logic [FRAME_FIELD_W-1:0] frame;
  } tlb_upd_t;

  // page table write: map a page, and optionally invalidate another one
  typedef struct packed {
    logic                     set_en;
    logic [PAGE_FIELD_W-1:0]  set_page;
    logic [FRAME_FIELD_W-1:0] set_frame;
    logic                     clr_en;
    logic [PAGE_FIELD_W-1:0]  clr_page;
  } pt_wr_t;

endpackage

FILE: src/tpt_tlb.sv
// fully associative tlb with fifo order kept by shifting entries down
// depends on tpt_pkg for the update struct
module tpt_tlb import tpt_pkg::*; #(
  parameter int ENTRIES = TLB_ENTRIES_DEF,
  parameter int PW      = 8,
  parameter int FW      = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [PW-1:0]              key_i,
  output logic                       hit_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic [FW-1:0]              hit_frame_o,
  input  tlb_upd_t                   upd_i
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [PW-1:0] tag_q   [ENTRIES];
  logic [FW-1:0] frame_q [ENTRIES];
  logic [CW-1:0] fill_q;

  logic [PW-1:0] tag1 [ENTRIES];
  logic [FW-1:0] frm1 [ENTRIES];
  logic [PW-1:0] tag2 [ENTRIES];
  logic [FW-1:0] frm2 [ENTRIES];
  logic [PW-1:0] tag_d   [ENTRIES];
  logic [FW-1:0] frame_d [ENTRIES];
  logic [CW-1:0] fill1, fill2, fill_d;
  logic [IW-1:0] rem_idx;

  // lookup, lowest matching slot wins
  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (CW'(i) < fill_q && tag_q[i] == key_i) begin
        hit_o     = 1'b1;
        hit_idx_o = IW'(i);
      end
    end
  end

  assign hit_frame_o = frame_q[hit_idx_o];
  assign rem_idx     = upd_i.rem_idx[IW-1:0];

  always_comb begin
    // removal at a given slot
    for (int i = 0; i < ENTRIES; i++) begin
      tag1[i] = tag_q[i];
      frm1[i] = frame_q[i];
    end
    for (int i = 0; i < ENTRIES - 1; i++) begin
      if (upd_i.rem && IW'(i) >= rem_idx) begin
        tag1[i] = tag_q[i+1];
        frm1[i] = frame_q[i+1];
      end
    end
    fill1 = upd_i.rem ? fill_q - CW'(1) : fill_q;

    // full on insert: drop the oldest
    for (int i = 0; i < ENTRIES; i++) begin
      tag2[i] = tag1[i];
      frm2[i] = frm1[i];
    end
    fill2 = fill1;
    if (upd_i.ins && fill1 == CW'(ENTRIES)) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        tag2[i] = tag1[i+1];
        frm2[i] = frm1[i+1];
      end
      fill2 = fill1 - CW'(1);
    end

    // append at the tail
    for (int i = 0; i < ENTRIES; i++) begin
      tag_d[i]   = tag2[i];
      frame_d[i] = frm2[i];
      if (upd_i.ins && CW'(i) == fill2) begin
        tag_d[i]   = upd_i.page[PW-1:0];
        frame_d[i] = upd_i.frame[FW-1:0];
      end
    end
    fill_d = upd_i.ins ? fill2 + CW'(1) : fill2;
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    frame_q <= frame_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

FILE: src/tpt_page_table.sv
// page table: page to frame map in a synchronous memory, valid bits in flops
// depends on tpt_pkg for the write struct
module tpt_page_table import tpt_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int FW         = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_page_i,
  output logic [FW-1:0]                 rd_frame_o,
  input  logic [$clog2(PAGE_COUNT)-1:0] vld_page_i,
  output logic                          vld_o,
  input  pt_wr_t                        wr_i
);

  localparam int PW = $clog2(PAGE_COUNT);

  logic [FW-1:0]         map_mem [PAGE_COUNT];
  logic [FW-1:0]         rd_q;
  logic [PAGE_COUNT-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.set_en) begin
      map_mem[wr_i.set_page[PW-1:0]] <= wr_i.set_frame[FW-1:0];
    end
    if (rd_en_i) begin
      rd_q <= map_mem[rd_page_i];
    end
  end

  assign rd_frame_o = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_i.clr_en) begin
        valid_q[wr_i.clr_page[PW-1:0]] <= 1'b0;
      end
      if (wr_i.set_en) begin
        valid_q[wr_i.set_page[PW-1:0]] <= 1'b1;
      end
    end
  end

  assign vld_o = valid_q[vld_page_i];

endmodule

FILE: src/tpt_frame_owner.sv
// frame owner memory: which page was last given each frame
// depends on tpt_pkg only through the shared defaults
module tpt_frame_owner import tpt_pkg::*; #(
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int PW          = 8
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [$clog2(FRAME_COUNT)-1:0] wr_frame_i,
  input  logic [PW-1:0]                  wr_page_i,
  input  logic                           rd_en_i,
  input  logic [$clog2(FRAME_COUNT)-1:0] rd_frame_i,
  output logic [PW-1:0]                  rd_page_o
);

  logic [PW-1:0] owner_mem [FRAME_COUNT];
  logic [PW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      owner_mem[wr_frame_i] <= wr_page_i;
    end
    if (rd_en_i) begin
      rd_q <= owner_mem[rd_frame_i];
    end
  end

  assign rd_page_o = rd_q;

endmodule

FILE: src/tlb_page_table_translator_top.sv
// flow: an accepted input beat passes the look state (tlb compare and memory reads), then the
// decide state, and on a fault once all frames are used the evict state (owner check)
// commit loads the result register; a new input beat is taken only in the idle state, once the
// last one has committed, and commit waits while a held result is stalled
// reset: page valid bits, tlb fill, frame pointer and counters clear at once, no clearing pass
// depends on tpt_pkg, tpt_tlb, tpt_page_table, tpt_frame_owner
module tlb_page_table_translator_top import tpt_pkg::*; #(
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [VA_W-1:0]          virtual_address_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [VA_W-1:0]          physical_address_o,
  output logic [FRAME_FIELD_W-1:0] frame_number_o,
  output logic [1:0]               outcome_o,
  output logic [PAGE_FIELD_W-1:0]  fetch_page_o,
  output logic                     evicted_valid_o,
  output logic [PAGE_FIELD_W-1:0]  evicted_page_o,
  output logic [CNT_W-1:0]         hit_total_o,
  output logic [CNT_W-1:0]         miss_total_o,
  output logic [CNT_W-1:0]         fault_total_o,
  // frames_in_use register write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int PW = $clog2(PAGE_COUNT);
  localparam int FW = $clog2(FRAME_COUNT);
  localparam int IW = $clog2(TLB_ENTRIES);

  // sequencer: accept, tlb compare plus memory reads, decide/commit, optional
  // second page table read to check the owner of a reused frame
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_EVICT
  } st_e;

  st_e st_q, st_d;

  logic [PW-1:0]          page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic                   tlb_hit_q;
  logic [FW-1:0]          tlb_frame_q;
  logic [FW-1:0]          next_frame_q;
  logic                   frames_full_q;
  logic [CFG_W-1:0]       frames_in_use_q;
  logic [CNT_W-1:0]       hit_cnt_q, miss_cnt_q, fault_cnt_q;

  // result register
  logic                     out_valid_q;
  logic [VA_W-1:0]          out_pa_q;
  logic [FRAME_FIELD_W-1:0] out_frame_q;
  outcome_e                 out_outcome_q;
  logic [PAGE_FIELD_W-1:0]  out_fetch_q;
  logic                     out_ev_valid_q;
  logic [PAGE_FIELD_W-1:0]  out_ev_page_q;

  // page number reduction modulo page count, worked out at elaboration
  logic [PW-1:0] page_mod_tbl [256];
  for (genvar g = 0; g < 256; g++) begin : g_pmod
    assign page_mod_tbl[g] = PW'(g % PAGE_COUNT);
  end

  logic                      tlb_hit;
  logic [IW-1:0]             tlb_hit_idx;
  logic [FW-1:0]             tlb_hit_frame;
  logic [PW-1:0]             tlb_key;
  tlb_upd_t                  tlb_upd;

  logic                      pt_rd_en;
  logic [PW-1:0]             pt_rd_page;
  logic [FW-1:0]             pt_rd_frame;
  logic                      pt_vld;
  pt_wr_t                    pt_wr;

  logic [PW-1:0]             owner_rd;
  logic [PW-1:0]             owner_page;

  logic                      out_free;
  logic                      commit;
  logic                      go_fault;
  logic                      evict;
  outcome_e                  res_outcome;
  logic [FW-1:0]             res_frame;

  logic [CFG_W-1:0]          frame_limit;
  logic [CFG_W-1:0]          nf_inc;

  // owner read from memory may be stale garbage, so reduce it like any page
  assign owner_page = page_mod_tbl[8'(owner_rd)];

  // the tlb and the valid bits look at the owner only while checking eviction
  assign tlb_key  = (st_q == ST_EVICT) ? owner_page : page_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // register value 0 acts as 1, values above the frame count clamp
  always_comb begin
    if (frames_in_use_q == '0) begin
      frame_limit = CFG_W'(1);
    end else if (frames_in_use_q > CFG_W'(FRAME_COUNT)) begin
      frame_limit = CFG_W'(FRAME_COUNT);
    end else begin
      frame_limit = frames_in_use_q;
    end
  end

  assign nf_inc = CFG_W'(next_frame_q) + CFG_W'(1);

  always_comb begin
    st_d        = st_q;
    commit      = 1'b0;
    go_fault    = 1'b0;
    evict       = 1'b0;
    res_outcome = OC_TLB_HIT;
    res_frame   = tlb_frame_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          st_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        st_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (tlb_hit_q) begin
          commit = out_free;
        end else if (pt_vld) begin
          res_outcome = OC_PT_HIT;
          res_frame   = pt_rd_frame;
          commit      = out_free;
        end else if (frames_full_q) begin
          // frame is being reused, its old owner must be checked first
          st_d = ST_EVICT;
        end else begin
          res_outcome = OC_FAULT;
          res_frame   = next_frame_q;
          go_fault    = 1'b1;
          commit      = out_free;
        end
      end
      ST_EVICT: begin
        res_outcome = OC_FAULT;
        res_frame   = next_frame_q;
        go_fault    = 1'b1;
        // owner still maps to this frame: it loses it
        evict       = pt_vld && (pt_rd_frame == next_frame_q);
        commit      = out_free;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    if (commit) begin
      st_d = ST_IDLE;
    end
  end

  // memory reads: page in the look cycle, reused frame's owner on a replacing fault
  assign pt_rd_en   = (st_q == ST_LOOK) ||
                      (st_q == ST_DECIDE && !tlb_hit_q && !pt_vld && frames_full_q);
  assign pt_rd_page = (st_q == ST_LOOK) ? page_q : owner_page;

  // all state updates land in the commit cycle, so no read can overlap a write
  always_comb begin
    pt_wr.set_en    = commit && go_fault;
    pt_wr.set_page  = PAGE_FIELD_W'(page_q);
    pt_wr.set_frame = FRAME_FIELD_W'(next_frame_q);
    pt_wr.clr_en    = commit && evict;
    pt_wr.clr_page  = PAGE_FIELD_W'(owner_page);

    tlb_upd.ins     = commit && (res_outcome != OC_TLB_HIT);
    tlb_upd.rem     = commit && evict && tlb_hit;
    tlb_upd.rem_idx = TLB_IDX_MAX_W'(tlb_hit_idx);
    tlb_upd.page    = PAGE_FIELD_W'(page_q);
    tlb_upd.frame   = FRAME_FIELD_W'(res_frame);
  end

  tpt_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .PW      (PW),
    .FW      (FW)
  ) u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (tlb_key),
    .hit_o       (tlb_hit),
    .hit_idx_o   (tlb_hit_idx),
    .hit_frame_o (tlb_hit_frame),
    .upd_i       (tlb_upd)
  );

  tpt_page_table #(
    .PAGE_COUNT (PAGE_COUNT),
    .FW         (FW)
  ) u_page_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (pt_rd_en),
    .rd_page_i  (pt_rd_page),
    .rd_frame_o (pt_rd_frame),
    .vld_page_i (tlb_key),
    .vld_o      (pt_vld),
    .wr_i       (pt_wr)
  );

  tpt_frame_owner #(
    .FRAME_COUNT (FRAME_COUNT),
    .PW          (PW)
  ) u_frame_owner (
    .clk_i      (clk_i),
    .wr_en_i    (commit && go_fault),
    .wr_frame_i (next_frame_q),
    .wr_page_i  (page_q),
    .rd_en_i    (st_q == ST_LOOK),
    .rd_frame_i (next_frame_q),
    .rd_page_o  (owner_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ST_IDLE;
      page_q          <= '0;
      offset_q        <= '0;
      tlb_hit_q       <= 1'b0;
      tlb_frame_q     <= '0;
      next_frame_q    <= '0;
      frames_full_q   <= 1'b0;
      frames_in_use_q <= FRAMES_RESET;
      hit_cnt_q       <= '0;
      miss_cnt_q      <= '0;
      fault_cnt_q     <= '0;
      out_valid_q     <= 1'b0;
      out_pa_q        <= '0;
      out_frame_q     <= '0;
      out_outcome_q   <= OC_TLB_HIT;
      out_fetch_q     <= '0;
      out_ev_valid_q  <= 1'b0;
      out_ev_page_q   <= '0;
    end else begin
      st_q <= st_d;

      if (cfg_valid_i) begin
        frames_in_use_q <= cfg_data_i;
      end

      if (st_q == ST_IDLE && in_valid_i) begin
        page_q   <= page_mod_tbl[virtual_address_i[VA_W-1:OFFSET_BITS]];
        offset_q <= virtual_address_i[OFFSET_BITS-1:0];
      end

      if (st_q == ST_LOOK) begin
        tlb_hit_q   <= tlb_hit;
        tlb_frame_q <= tlb_hit_frame;
      end

      if (commit) begin
        out_valid_q    <= 1'b1;
        out_pa_q       <= {FRAME_FIELD_W'(res_frame), offset_q};
        out_frame_q    <= FRAME_FIELD_W'(res_frame);
        out_outcome_q  <= res_outcome;
        out_fetch_q    <= go_fault ? PAGE_FIELD_W'(page_q) : '0;
        out_ev_valid_q <= evict;
        out_ev_page_q  <= evict ? PAGE_FIELD_W'(owner_page) : '0;

        unique case (res_outcome)
          OC_TLB_HIT: hit_cnt_q  <= hit_cnt_q + CNT_W'(1);
          OC_PT_HIT:  miss_cnt_q <= miss_cnt_q + CNT_W'(1);
          default:    fault_cnt_q <= fault_cnt_q + CNT_W'(1);
        endcase

        if (go_fault) begin
          // fifo frame pointer wraps at the limit, from then on frames are reused
          if (nf_inc >= frame_limit) begin
            next_frame_q  <= '0;
            frames_full_q <= 1'b1;
          end else begin
            next_frame_q <= nf_inc[FW-1:0];
          end
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // one item at a time; counters only move at commit, which waits for a free result slot
  assign in_stall_o         = (st_q != ST_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_pa_q;
  assign frame_number_o     = out_frame_q;
  assign outcome_o          = out_outcome_q;
  assign fetch_page_o       = out_fetch_q;
  assign evicted_valid_o    = out_ev_valid_q;
  assign evicted_page_o     = out_ev_page_q;
  assign hit_total_o        = hit_cnt_q;
  assign miss_total_o       = miss_cnt_q;
  assign fault_total_o      = fault_cnt_q;

  // an eviction only ever comes with a page fault
  a_evict_on_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> outcome_o == OC_FAULT)
    else $error("eviction reported without a page fault");

  // every committed beat bumps exactly one of the three counters
  a_one_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> CNT_W'(hit_cnt_q + miss_cnt_q + fault_cnt_q) ==
               CNT_W'($past(hit_cnt_q + miss_cnt_q + fault_cnt_q) + CNT_W'(1)))
    else $error("counter totals did not advance by one");

  // physical address upper byte is the reported frame
  a_pa_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> physical_address_o[VA_W-1:OFFSET_BITS] == frame_number_o)
    else $error("physical address does not match frame number");

endmodule
